FILE: hw/rtl/aebu_pkg.sv
// ----------------------------------------------------------------------------
// aebu_pkg
// Shared types, codes and constants of the ADC event block unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package aebu_pkg;

  // Default geometry of the histogram store
  localparam int NUM_CHANNELS_DEF = 32;
  localparam int HIST_BINS_DEF    = 4096;

  // Event list length; the last slot absorbs every later hit
  localparam int MAX_HITS = 96;
  localparam logic [6:0] HIT_LAST = 7'(MAX_HITS - 1);

  // Field widths of the stream word and of the result item
  localparam int LEN_W   = 13;
  localparam int CH_FW   = 5;
  localparam int VAL_FW  = 12;
  localparam int SLOT_W  = 7;
  localparam int CNT_W   = 32;

  // Result queue
  localparam int RQ_DEPTH = 3;
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);
  localparam int RQ_IDX_W = $clog2(RQ_DEPTH);

  // Command codes
  localparam logic [1:0] CMD_NEW  = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HIT  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_MODHDR = 2'd1,
    PH_DATA   = 2'd2,
    PH_BROKEN = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CH_FW-1:0]  hit_channel;
    logic [VAL_FW-1:0] hit_value;
    logic [SLOT_W-1:0] hit_slot;
    logic              block_done;
    logic [CNT_W-1:0]  broken_total;
    logic [CNT_W-1:0]  bin_count;
  } result_t;

  // Histogram access issued with an accepted item
  typedef struct packed {
    logic inc;
    logic rd;
  } hist_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/aebu_if.sv
// ----------------------------------------------------------------------------
// aebu_if
// Valid/ready channels of the ADC event block unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

interface aebu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] word;
  logic [4:0]  read_channel;
  logic [11:0] read_bin;

  modport source (output valid, cmd, word, read_channel, read_bin, input ready);
  modport sink   (input valid, cmd, word, read_channel, read_bin, output ready);
endinterface

interface aebu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  hit_channel;
  logic [11:0] hit_value;
  logic [6:0]  hit_slot;
  logic        block_done;
  logic [31:0] broken_total;
  logic [31:0] bin_count;

  modport source (output valid, kind, hit_channel, hit_value, hit_slot, block_done,
                  broken_total, bin_count, input ready);
  modport sink   (input valid, kind, hit_channel, hit_value, hit_slot, block_done,
                  broken_total, bin_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/aebu_parse.sv
// ----------------------------------------------------------------------------
// aebu_parse
// Block parser: tracks header/data phase, word count, event list slot and
// broken-block count; issues the histogram access of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module aebu_parse #(
  parameter int NUM_CHANNELS = aebu_pkg::NUM_CHANNELS_DEF,
  parameter int HIST_BINS    = aebu_pkg::HIST_BINS_DEF,
  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int BIN_W       = $clog2(HIST_BINS),
  localparam int ADDR_W      = CH_W + BIN_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [1:0]                  cmd,
  input  wire logic [31:0]                 word,
  input  wire logic [aebu_pkg::CH_FW-1:0]  read_channel,
  input  wire logic [aebu_pkg::VAL_FW-1:0] read_bin,
  output aebu_pkg::result_t                res,
  output aebu_pkg::hist_op_t               op,
  output logic [ADDR_W-1:0]                addr
);

  localparam logic [aebu_pkg::CH_FW:0]  CH_LIM  = (aebu_pkg::CH_FW + 1)'(NUM_CHANNELS);
  localparam logic [aebu_pkg::VAL_FW:0] BIN_LIM = (aebu_pkg::VAL_FW + 1)'(HIST_BINS);

  aebu_pkg::phase_t                 phase, phase_next;
  logic [aebu_pkg::LEN_W-1:0]       words_left, words_left_next;
  logic [aebu_pkg::SLOT_W-1:0]      hit_count, hit_count_next;
  logic [aebu_pkg::CNT_W-1:0]       broken_count, broken_count_next;

  logic [aebu_pkg::LEN_W-1:0]       len;
  logic [aebu_pkg::LEN_W-1:0]       wl_dec;
  logic [aebu_pkg::CH_FW-1:0]       hit_ch;
  logic [aebu_pkg::VAL_FW-1:0]      hit_val;
  logic                             is_hit;
  logic                             hit_in_range;
  logic                             rd_in_range;

  assign len     = word[aebu_pkg::LEN_W-1:0];
  assign wl_dec  = words_left - aebu_pkg::LEN_W'(1);
  assign hit_ch  = word[20:16];
  assign hit_val = word[11:0];
  assign is_hit  = (word[26:21] == 6'd0);

  assign hit_in_range = ({1'b0, hit_ch} < CH_LIM) && ({1'b0, hit_val} < BIN_LIM);
  assign rd_in_range  = ({1'b0, read_channel} < CH_LIM) && ({1'b0, read_bin} < BIN_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= aebu_pkg::PH_HEADER;
      words_left   <= '0;
      hit_count    <= '0;
      broken_count <= '0;
    end else begin
      phase        <= phase_next;
      words_left   <= words_left_next;
      hit_count    <= hit_count_next;
      broken_count <= broken_count_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    words_left_next   = words_left;
    hit_count_next    = hit_count;
    broken_count_next = broken_count;
    res               = '0;
    res.kind          = aebu_pkg::KIND_NONE;
    op                = '0;
    addr              = {read_channel[CH_W-1:0], read_bin[BIN_W-1:0]};

    if (accept) begin
      unique case (cmd)
        aebu_pkg::CMD_NEW: begin
          hit_count_next  = '0;
          words_left_next = '0;
          phase_next      = aebu_pkg::PH_HEADER;
        end
        aebu_pkg::CMD_DATA: begin
          unique case (phase)
            aebu_pkg::PH_HEADER: begin
              if (len > aebu_pkg::LEN_W'(1)) begin
                words_left_next = len - aebu_pkg::LEN_W'(1);
                phase_next      = aebu_pkg::PH_MODHDR;
              end else if (len == aebu_pkg::LEN_W'(1)) begin
                broken_count_next = broken_count + aebu_pkg::CNT_W'(1);
                phase_next        = aebu_pkg::PH_BROKEN;
              end else begin
                res.block_done = 1'b1;
              end
            end
            aebu_pkg::PH_MODHDR: begin
              phase_next = aebu_pkg::PH_DATA;
            end
            aebu_pkg::PH_DATA: begin
              if (is_hit) begin
                res.kind        = aebu_pkg::KIND_HIT;
                res.hit_channel = hit_ch;
                res.hit_value   = hit_val;
                res.hit_slot    = hit_count;
                // saturate on the last event list slot
                if (hit_count >= aebu_pkg::HIT_LAST) begin
                  hit_count_next = aebu_pkg::HIT_LAST;
                end else begin
                  hit_count_next = hit_count + aebu_pkg::SLOT_W'(1);
                end
                op.inc = hit_in_range;
                addr   = {hit_ch[CH_W-1:0], hit_val[BIN_W-1:0]};
              end
              words_left_next = wl_dec;
              if (wl_dec == '0) begin
                phase_next     = aebu_pkg::PH_HEADER;
                res.block_done = 1'b1;
              end
            end
            aebu_pkg::PH_BROKEN: begin
              phase_next     = aebu_pkg::PH_HEADER;
              res.block_done = 1'b1;
            end
          endcase
        end
        aebu_pkg::CMD_READ: begin
          res.kind = aebu_pkg::KIND_READ;
          op.rd    = rd_in_range;
        end
        default: begin
        end
      endcase
    end

    res.broken_total = broken_count_next;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/aebu_hist.sv
// ----------------------------------------------------------------------------
// aebu_hist
// Histogram store: registered read, saturating increment written back the
// next cycle, forwarding of the previous write, clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module aebu_hist #(
  parameter int NUM_CHANNELS = aebu_pkg::NUM_CHANNELS_DEF,
  parameter int HIST_BINS    = aebu_pkg::HIST_BINS_DEF,
  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int BIN_W       = $clog2(HIST_BINS),
  localparam int ADDR_W      = CH_W + BIN_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire aebu_pkg::hist_op_t         op,
  input  wire logic [ADDR_W-1:0]          addr,
  output logic                            busy,
  output logic [aebu_pkg::CNT_W-1:0]      bin_count
);

  localparam int DEPTH  = NUM_CHANNELS * (2 ** BIN_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [aebu_pkg::CNT_W-1:0] mem [DEPTH];

  logic                       clearing;
  logic [ADDR_W-1:0]          clr_addr;
  aebu_pkg::hist_op_t         op_q;
  logic [ADDR_W-1:0]          addr_q;
  logic [aebu_pkg::CNT_W-1:0] rdata;
  logic                       fwd_valid;
  logic [ADDR_W-1:0]          fwd_addr;
  logic [aebu_pkg::CNT_W-1:0] fwd_data;

  logic                       we;
  logic [ADDR_W-1:0]          wa;
  logic [aebu_pkg::CNT_W-1:0] wd;
  logic [aebu_pkg::CNT_W-1:0] cur;
  logic [aebu_pkg::CNT_W-1:0] inc_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q      <= '0;
      fwd_valid <= 1'b0;
    end else begin
      op_q      <= op;
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    addr_q   <= addr;
    fwd_addr <= wa;
    fwd_data <= wd;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[addr];
  end

  // the write of the previous cycle is not yet visible in rdata
  assign cur      = (fwd_valid && (fwd_addr == addr_q)) ? fwd_data : rdata;
  assign inc_data = (&cur) ? cur : cur + aebu_pkg::CNT_W'(1);

  assign we = clearing || op_q.inc;
  assign wa = clearing ? clr_addr : addr_q;
  assign wd = clearing ? '0 : inc_data;

  assign busy      = clearing;
  assign bin_count = op_q.rd ? cur : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/aebu_rq.sv
// ----------------------------------------------------------------------------
// aebu_rq
// Result queue: a short shift queue whose head register drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module aebu_rq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire aebu_pkg::result_t             din,
  input  wire logic                          pop,
  output aebu_pkg::result_t                  dout,
  output logic [aebu_pkg::RQ_CNT_W-1:0]      count
);

  aebu_pkg::result_t                ent [aebu_pkg::RQ_DEPTH];
  logic [aebu_pkg::RQ_IDX_W-1:0]    wr_idx;
  logic [aebu_pkg::RQ_CNT_W-1:0]    count_next;

  assign wr_idx     = aebu_pkg::RQ_IDX_W'(count - aebu_pkg::RQ_CNT_W'(pop));
  assign count_next = count + aebu_pkg::RQ_CNT_W'(push) - aebu_pkg::RQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // each entry takes the new item, its successor or holds
  always_ff @(posedge clk) begin
    for (int i = 0; i < aebu_pkg::RQ_DEPTH - 1; i++) begin
      if (push && (wr_idx == aebu_pkg::RQ_IDX_W'(i))) begin
        ent[i] <= din;
      end else if (pop) begin
        ent[i] <= ent[i + 1];
      end
    end
    if (push && (wr_idx == aebu_pkg::RQ_IDX_W'(aebu_pkg::RQ_DEPTH - 1))) begin
      ent[aebu_pkg::RQ_DEPTH - 1] <= din;
    end
  end

  assign dout = ent[0];

endmodule

`default_nettype wire

FILE: hw/rtl/adc_event_block_unpacker.sv
// ----------------------------------------------------------------------------
// adc_event_block_unpacker
// Peak-ADC event block unpacker with per-channel amplitude histogram.
// ----------------------------------------------------------------------------
// Items enter on req (cmd, word, read_channel, read_bin) and leave on rsp,
// one result item per input item, in order. Both channels are valid/ready.
// cmd 1 feeds one stream word to the block parser, cmd 0 starts a new event,
// cmd 2 reads one histogram bin.
// Throughput: one item per cycle while req.ready is high. The histogram
// read-modify-write is split into a synchronous read and then a saturating
// increment written back, with the previous write forwarded, so back-to-back
// hits on one bin count correctly.
// An accepted item passes the histogram stage, then the result queue to rsp.
// Reset: parser state and counters clear at once; then the histogram memory
// is swept to zero, one entry per cycle; req.ready stays low until it ends.
// Stall: a three-entry result queue holds finished items; besides the clear,
// req.ready drops when the queue plus the item in the histogram stage fill it,
// and it comes from registers only.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_event_block_unpacker #(
  parameter int NUM_CHANNELS = aebu_pkg::NUM_CHANNELS_DEF,
  parameter int HIST_BINS    = aebu_pkg::HIST_BINS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  aebu_in_if.sink   req,
  aebu_out_if.source rsp
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BIN_W  = $clog2(HIST_BINS);
  localparam int ADDR_W = CH_W + BIN_W;
  localparam logic [aebu_pkg::RQ_CNT_W:0] Q_LIMIT =
    aebu_pkg::RQ_DEPTH[aebu_pkg::RQ_CNT_W:0];

  logic                              accept;
  aebu_pkg::result_t                 p_res;
  aebu_pkg::hist_op_t                p_op;
  logic [ADDR_W-1:0]                 p_addr;
  logic                              hist_busy;
  logic [aebu_pkg::CNT_W-1:0]        hist_count;

  logic                              s1_valid;
  aebu_pkg::result_t                 s1_res;
  aebu_pkg::result_t                 push_res;
  aebu_pkg::result_t                 head;
  logic [aebu_pkg::RQ_CNT_W-1:0]     rq_count;
  logic [aebu_pkg::RQ_CNT_W:0]       inflight;
  logic                              pop;

  assign inflight  = {1'b0, rq_count} + {{aebu_pkg::RQ_CNT_W{1'b0}}, s1_valid};
  assign req.ready = !hist_busy && (inflight < Q_LIMIT);
  assign accept    = req.valid && req.ready;

  aebu_parse #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .HIST_BINS    (HIST_BINS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (req.cmd),
    .word         (req.word),
    .read_channel (req.read_channel),
    .read_bin     (req.read_bin),
    .res          (p_res),
    .op           (p_op),
    .addr         (p_addr)
  );

  aebu_hist #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .HIST_BINS    (HIST_BINS)
  ) u_hist (
    .clk       (clk),
    .rst       (rst),
    .op        (p_op),
    .addr      (p_addr),
    .busy      (hist_busy),
    .bin_count (hist_count)
  );

  // histogram stage: the item waits in this register for the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= p_res;
    end
  end

  always_comb begin
    push_res           = s1_res;
    push_res.bin_count = hist_count;
  end

  assign pop = rsp.valid && rsp.ready;

  aebu_rq u_rq (
    .clk   (clk),
    .rst   (rst),
    .push  (s1_valid),
    .din   (push_res),
    .pop   (pop),
    .dout  (head),
    .count (rq_count)
  );

  assign rsp.valid        = (rq_count != '0);
  assign rsp.kind         = head.kind;
  assign rsp.hit_channel  = head.hit_channel;
  assign rsp.hit_value    = head.hit_value;
  assign rsp.hit_slot     = head.hit_slot;
  assign rsp.block_done   = head.block_done;
  assign rsp.broken_total = head.broken_total;
  assign rsp.bin_count    = head.bin_count;

  // the queue never takes an item it has no room for
  a_rq_no_overflow : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !pop |-> ({1'b0, rq_count} < Q_LIMIT))
    else $error("result queue overflow");

  // only bin reads carry histogram data
  a_count_only_on_read : assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_res.kind != aebu_pkg::KIND_READ) |-> (hist_count == '0))
    else $error("histogram data on a non-read item");

  // nothing enters while the histogram is being cleared
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (rst)
    hist_busy |=> !s1_valid)
    else $error("item accepted during histogram clear");

endmodule

`default_nettype wire
